[rtl/ktint_pkg.sv]
// shared constants and types for the keyframe track interpolator
package ktint_pkg;

  parameter int MAX_KEYS_DEF   = 64;
  parameter int COMP_WIDTH_DEF = 32;

  // internal component width and shared multiplier operand width
  parameter int CALC_W = 34;
  parameter int MUL_W  = 33;

  parameter int PADDR_W     = 3;
  parameter int REG_SEL_BIT = 2;

  parameter logic OP_LOAD   = 1'b0;
  parameter logic OP_SAMPLE = 1'b1;

  parameter logic REG_KEY_COUNT   = 1'b0;
  parameter logic REG_INTERP_MODE = 1'b1;

  parameter logic MODE_VECTOR = 1'b0;
  parameter logic MODE_QUAT   = 1'b1;

  parameter logic [6:0]  KEY_COUNT_RST = 7'd1;
  parameter logic [16:0] ONE_Q16       = 17'd65536;

  parameter logic [5:0] SQRT_STEPS = 6'd32;
  parameter logic [5:0] DIV_STEPS  = 6'd17;

  typedef struct packed {
    logic start;
    logic op_sqrt;
  } dsu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } dsu_rsp_t;

endpackage

[rtl/ktint_if.sv]
// valid/ready channel interfaces for the input and result transactions
interface ktint_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [5:0]         key_slot;
  logic [31:0]        time_value;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic signed [31:0] comp_w;

  modport source (output valid, opcode, key_slot, time_value, comp_x, comp_y, comp_z, comp_w,
                  input ready);
  modport sink (input valid, opcode, key_slot, time_value, comp_x, comp_y, comp_z, comp_w,
                output ready);
endinterface

interface ktint_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               out_of_range;

  modport source (output valid, out_x, out_y, out_z, out_w, out_of_range, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, out_of_range, output ready);
endinterface

[rtl/ktint_ram.sv]
// generic single write port ram with registered read
module ktint_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ktint_divsqrt.sv]
// shared iterative unit: restoring divide (17 quotient bits) or 64-bit integer square root
module ktint_divsqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ktint_pkg::dsu_req_t req_i,
  input  logic [63:0]         opa_i,
  input  logic [31:0]         opb_i,
  output ktint_pkg::dsu_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic        sqrt_q;
  logic [35:0] rem_q;
  logic [63:0] sh_q;
  logic [31:0] res_q;
  logic [31:0] den_q;

  logic [35:0] cand;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  // one shared compare and subtract per step
  always_comb begin
    if (sqrt_q) begin
      cand  = {rem_q[33:0], sh_q[63:62]};
      trial = {2'b00, res_q, 2'b01};
    end else begin
      cand  = {rem_q[34:0], sh_q[63]};
      trial = {4'b0000, den_q};
    end
    ge   = (cand >= trial);
    diff = cand - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.op_sqrt ? ktint_pkg::SQRT_STEPS : ktint_pkg::DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.op_sqrt;
      den_q  <= opb_i;
      res_q  <= '0;
      if (req_i.op_sqrt) begin
        rem_q <= '0;
        sh_q  <= opa_i;
      end else begin
        // quotient fits 17 bits, so the upper numerator bits start below the divisor
        rem_q <= 36'(opa_i[47:17]);
        sh_q  <= {opa_i[16:0], 47'd0};
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff : cand;
      res_q <= {res_q[30:0], ge};
      sh_q  <= sqrt_q ? {sh_q[61:0], 2'b00} : {sh_q[62:0], 1'b0};
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

[rtl/keyframe_track_interpolator.sv]
// keyframe track interpolator top level: key store, sequencer, shared multiplier
// One animation track of up to MAX_KEYS keys (time plus four Q16.16 components) is held
// in two rams. A load transaction writes one key and gives no result. A sample
// transaction scans the key times linearly, finds the segment, divides for the blend
// factor (skipped when the query sits at or before the segment start) and blends.
// Quaternion mode normalizes both keys and the blend; each normalization runs four
// squares on the shared multiplier, a 32-step square root and, unless the magnitude is
// zero, four 17-step divides on the shared divide/root unit. A clamped or single-key
// sample returns a stored key. The block takes no new transaction while a sample is in
// work; a finished result waits in the output register and does not stall the next
// input. Configuration goes through the apb port at byte address 4*index and must only
// be written while the block is idle.
module keyframe_track_interpolator #(
  parameter int MAX_KEYS   = ktint_pkg::MAX_KEYS_DEF,
  parameter int COMP_WIDTH = ktint_pkg::COMP_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ktint_in_if.sink                      kin_i,
  ktint_out_if.source                   kout_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ktint_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int NW  = $clog2(MAX_KEYS + 1);
  localparam int CW  = COMP_WIDTH;
  localparam int VW  = 4 * COMP_WIDTH;
  localparam int CAW = ktint_pkg::CALC_W;
  localparam int MW  = ktint_pkg::MUL_W;
  localparam int PW  = 2 * ktint_pkg::MUL_W;
  localparam logic signed [PW-1:0] HALF_P = PW'(32768);

  // sequencer codes
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SCANA  = 5'd1;
  localparam logic [4:0] S_SCANB  = 5'd2;
  localparam logic [4:0] S_FACT   = 5'd3;
  localparam logic [4:0] S_FWAIT  = 5'd4;
  localparam logic [4:0] S_RDA    = 5'd5;
  localparam logic [4:0] S_RDB    = 5'd6;
  localparam logic [4:0] S_RDW    = 5'd7;
  localparam logic [4:0] S_RDC    = 5'd8;
  localparam logic [4:0] S_KEYA   = 5'd9;
  localparam logic [4:0] S_KEYB   = 5'd10;
  localparam logic [4:0] S_VMUL   = 5'd11;
  localparam logic [4:0] S_VACC   = 5'd12;
  localparam logic [4:0] S_NMAG   = 5'd13;
  localparam logic [4:0] S_NSQM   = 5'd14;
  localparam logic [4:0] S_NSQA   = 5'd15;
  localparam logic [4:0] S_NSQRT  = 5'd16;
  localparam logic [4:0] S_NSWAIT = 5'd17;
  localparam logic [4:0] S_NDIV   = 5'd18;
  localparam logic [4:0] S_NDWAIT = 5'd19;
  localparam logic [4:0] S_NRET   = 5'd20;
  localparam logic [4:0] S_DMUL   = 5'd21;
  localparam logic [4:0] S_DACC   = 5'd22;
  localparam logic [4:0] S_BMUL1  = 5'd23;
  localparam logic [4:0] S_BMUL2  = 5'd24;
  localparam logic [4:0] S_BSUM   = 5'd25;
  localparam logic [4:0] S_DONE   = 5'd26;

  // which vector the normalize routine works on
  localparam logic [1:0] RET_A   = 2'd0;
  localparam logic [1:0] RET_B   = 2'd1;
  localparam logic [1:0] RET_RES = 2'd2;

  // configuration registers
  logic [6:0] key_count_q;
  logic       interp_mode_q;

  // sequencer state and working registers
  logic [4:0]            state_q, state_d;
  logic [NW-1:0]         n_q, n_d;
  logic [NW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         vptr_q, vptr_d;
  logic [31:0]           t_q, t_d;
  logic [31:0]           prev_q, prev_d;
  logic [31:0]           next_q, next_d;
  logic                  vec_q, vec_d;
  logic                  flag_q, flag_d;
  logic [15:0]           f_q, f_d;
  logic signed [CAW-1:0] a_q [4];
  logic signed [CAW-1:0] a_d [4];
  logic signed [CAW-1:0] b_q [4];
  logic signed [CAW-1:0] b_d [4];
  logic signed [CAW-1:0] nv_q [4];
  logic signed [CAW-1:0] nv_d [4];
  logic [30:0]           mag_q [4];
  logic [30:0]           mag_d [4];
  logic [63:0]           acc_q, acc_d;
  logic [31:0]           r_q, r_d;
  logic [1:0]            idx_q, idx_d;
  logic [1:0]            ret_q, ret_d;
  logic                  dneg_q, dneg_d;
  logic signed [PW-1:0]  p1_q, p1_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic signed [31:0] ox_q, oy_q, oz_q, ow_q;
  logic               oflag_q;
  logic               out_load;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_q;

  // shared divide / root unit
  ktint_pkg::dsu_req_t dsu_req;
  ktint_pkg::dsu_rsp_t dsu_rsp;
  logic [63:0]         dsu_opa;
  logic [31:0]         dsu_opb;

  // key store
  logic          in_acc;
  logic          slot_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] val_wdata;
  logic [31:0]   time_rdata;
  logic [VW-1:0] val_rdata;

  // helpers
  logic signed [CAW-1:0] rd_comp [4];
  logic [CAW-1:0]        absv [4];
  logic                  big;
  logic signed [CAW-1:0] diff_ab;
  logic signed [CAW-1:0] bj;
  logic [16:0]           omf;
  logic [NW-1:0]         n_calc;
  logic [16:0]           qv;

  // ---------------------------------------------------------------------------
  // configuration port, register picked by paddr bit 2
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q   <= ktint_pkg::KEY_COUNT_RST;
      interp_mode_q <= ktint_pkg::MODE_VECTOR;
    end else if (psel && penable && pwrite) begin
      case (paddr[ktint_pkg::REG_SEL_BIT])
        ktint_pkg::REG_KEY_COUNT:   key_count_q   <= pwdata[6:0];
        ktint_pkg::REG_INTERP_MODE: interp_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ktint_pkg::REG_SEL_BIT])
      ktint_pkg::REG_INTERP_MODE: prdata = {31'd0, interp_mode_q};
      default:                    prdata = {25'd0, key_count_q};
    endcase
  end

  // ---------------------------------------------------------------------------
  // key store: times and packed component values
  // ---------------------------------------------------------------------------
  assign kin_i.ready = (state_q == S_IDLE);
  assign in_acc      = kin_i.valid && (state_q == S_IDLE);
  assign slot_ok     = (32'(kin_i.key_slot) < 32'(MAX_KEYS));
  assign ram_we      = in_acc && (kin_i.opcode == ktint_pkg::OP_LOAD) && slot_ok;
  assign ram_waddr   = AW'(kin_i.key_slot);
  assign val_wdata   = {kin_i.comp_w[CW-1:0], kin_i.comp_z[CW-1:0],
                        kin_i.comp_y[CW-1:0], kin_i.comp_x[CW-1:0]};

  ktint_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (kin_i.time_value),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (time_rdata)
  );

  ktint_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_wdata),
    .raddr_i (vptr_q),
    .rdata_o (val_rdata)
  );

  // sign-extend the stored components
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rd_comp[j] = CAW'($signed(val_rdata[j*CW +: CW]));
    end
  end

  // ---------------------------------------------------------------------------
  // shared divide / root unit
  // ---------------------------------------------------------------------------
  ktint_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dsu_req),
    .opa_i  (dsu_opa),
    .opb_i  (dsu_opb),
    .rsp_o  (dsu_rsp)
  );

  // ---------------------------------------------------------------------------
  // shared multiplier, registered product
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // clamped key count for a new sample
  always_comb begin
    if (key_count_q == 7'd0) begin
      n_calc = NW'(1);
    end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
      n_calc = NW'(MAX_KEYS);
    end else begin
      n_calc = NW'(key_count_q);
    end
  end

  // magnitudes for normalize, halved when any reaches 2^31
  always_comb begin
    big = 1'b0;
    for (int j = 0; j < 4; j++) begin
      absv[j] = nv_q[j][CAW-1] ? CAW'(-nv_q[j]) : CAW'(nv_q[j]);
      if (|absv[j][CAW-1:31]) begin
        big = 1'b1;
      end
    end
  end

  assign diff_ab = b_q[idx_q] - a_q[idx_q];
  assign bj      = dneg_q ? -b_q[idx_q] : b_q[idx_q];
  assign omf     = ktint_pkg::ONE_Q16 - {1'b0, f_q};
  assign qv      = dsu_rsp.result[16:0];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    vptr_d      = vptr_q;
    t_d         = t_q;
    prev_d      = prev_q;
    next_d      = next_q;
    vec_d       = vec_q;
    flag_d      = flag_q;
    f_d         = f_q;
    a_d         = a_q;
    b_d         = b_q;
    nv_d        = nv_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    r_d         = r_q;
    idx_d       = idx_q;
    ret_d       = ret_q;
    dneg_d      = dneg_q;
    p1_d        = p1_q;
    mul_a       = '0;
    mul_b       = '0;
    dsu_req     = '0;
    dsu_opa     = '0;
    dsu_opb     = '0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !kout_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_acc && (kin_i.opcode == ktint_pkg::OP_SAMPLE)) begin
          t_d   = kin_i.time_value;
          vec_d = (interp_mode_q == ktint_pkg::MODE_VECTOR);
          n_d   = n_calc;
          if (n_calc == NW'(1)) begin
            // single key: key 0 as stored
            vptr_d  = '0;
            flag_d  = 1'b0;
            state_d = S_KEYA;
          end else begin
            ptr_d   = '0;
            state_d = S_SCANA;
          end
        end
      end

      // time read in flight
      S_SCANA: state_d = S_SCANB;

      S_SCANB: begin
        if (ptr_q == '0) begin
          if (t_q < time_rdata) begin
            // before the first key
            vptr_d  = '0;
            flag_d  = 1'b1;
            state_d = S_KEYA;
          end else begin
            prev_d  = time_rdata;
            ptr_d   = NW'(1);
            state_d = S_SCANA;
          end
        end else if (t_q < time_rdata) begin
          next_d  = time_rdata;
          vptr_d  = AW'(ptr_q - NW'(1));
          state_d = S_FACT;
        end else if (ptr_q == n_q - NW'(1)) begin
          // at or past the last key
          vptr_d  = AW'(n_q - NW'(1));
          flag_d  = (t_q > time_rdata);
          state_d = S_KEYA;
        end else begin
          prev_d  = time_rdata;
          ptr_d   = ptr_q + NW'(1);
          state_d = S_SCANA;
        end
      end

      S_FACT: begin
        flag_d = 1'b0;
        if (t_q > prev_q) begin
          dsu_req.start = 1'b1;
          dsu_opa       = {16'd0, t_q - prev_q, 16'd0};
          dsu_opb       = next_q - prev_q;
          state_d       = S_FWAIT;
        end else begin
          f_d     = '0;
          state_d = S_RDA;
        end
      end

      S_FWAIT: begin
        if (dsu_rsp.done) begin
          f_d     = dsu_rsp.result[15:0];
          state_d = S_RDA;
        end
      end

      S_RDA: state_d = S_RDB;

      S_RDB: begin
        a_d     = rd_comp;
        vptr_d  = vptr_q + AW'(1);
        state_d = S_RDW;
      end

      S_RDW: state_d = S_RDC;

      S_RDC: begin
        b_d   = rd_comp;
        idx_d = '0;
        if (vec_q) begin
          state_d = S_VMUL;
        end else begin
          nv_d    = a_q;
          ret_d   = RET_A;
          state_d = S_NMAG;
        end
      end

      S_KEYA: state_d = S_KEYB;

      S_KEYB: begin
        nv_d    = rd_comp;
        state_d = S_DONE;
      end

      // vector blend: a + round((b - a) * f / 65536)
      S_VMUL: begin
        mul_a   = MW'(diff_ab);
        mul_b   = MW'(f_q);
        state_d = S_VACC;
      end

      S_VACC: begin
        nv_d[idx_q] = a_q[idx_q] + CAW'((mul_q + HALF_P) >>> 16);
        idx_d       = idx_q + 2'd1;
        state_d     = (idx_q == 2'd3) ? S_DONE : S_VMUL;
      end

      // normalize routine on nv
      S_NMAG: begin
        for (int j = 0; j < 4; j++) begin
          mag_d[j] = big ? absv[j][31:1] : absv[j][30:0];
        end
        acc_d   = '0;
        idx_d   = '0;
        state_d = S_NSQM;
      end

      S_NSQM: begin
        mul_a   = MW'(mag_q[idx_q]);
        mul_b   = MW'(mag_q[idx_q]);
        state_d = S_NSQA;
      end

      S_NSQA: begin
        acc_d   = acc_q + mul_q[63:0];
        idx_d   = idx_q + 2'd1;
        state_d = (idx_q == 2'd3) ? S_NSQRT : S_NSQM;
      end

      S_NSQRT: begin
        dsu_req.start   = 1'b1;
        dsu_req.op_sqrt = 1'b1;
        dsu_opa         = acc_q;
        state_d         = S_NSWAIT;
      end

      S_NSWAIT: begin
        if (dsu_rsp.done) begin
          r_d   = dsu_rsp.result;
          idx_d = '0;
          // zero quaternion stays as it is
          state_d = (dsu_rsp.result == 32'd0) ? S_NRET : S_NDIV;
        end
      end

      S_NDIV: begin
        dsu_req.start = 1'b1;
        dsu_opa       = 64'({mag_q[idx_q], 16'd0}) + 64'(r_q >> 1);
        dsu_opb       = r_q;
        state_d       = S_NDWAIT;
      end

      S_NDWAIT: begin
        if (dsu_rsp.done) begin
          nv_d[idx_q] = nv_q[idx_q][CAW-1] ? -$signed(CAW'(qv)) : $signed(CAW'(qv));
          idx_d       = idx_q + 2'd1;
          state_d     = (idx_q == 2'd3) ? S_NRET : S_NDIV;
        end
      end

      S_NRET: begin
        case (ret_q)
          RET_A: begin
            a_d     = nv_q;
            nv_d    = b_q;
            ret_d   = RET_B;
            state_d = S_NMAG;
          end
          RET_B: begin
            b_d     = nv_q;
            acc_d   = '0;
            idx_d   = '0;
            state_d = S_DMUL;
          end
          default: state_d = S_DONE;
        endcase
      end

      // dot product of the normalized keys
      S_DMUL: begin
        mul_a   = MW'(a_q[idx_q]);
        mul_b   = MW'(b_q[idx_q]);
        state_d = S_DACC;
      end

      S_DACC: begin
        acc_d = acc_q + mul_q[63:0];
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          dneg_d  = acc_d[63];
          state_d = S_BMUL1;
        end else begin
          state_d = S_DMUL;
        end
      end

      // blend: round((a * (1 - f) + b * f) / 65536), b flipped on negative dot
      S_BMUL1: begin
        mul_a   = MW'(a_q[idx_q]);
        mul_b   = MW'(omf);
        state_d = S_BMUL2;
      end

      S_BMUL2: begin
        p1_d    = mul_q;
        mul_a   = MW'(bj);
        mul_b   = MW'(f_q);
        state_d = S_BSUM;
      end

      S_BSUM: begin
        nv_d[idx_q] = CAW'((p1_q + mul_q + HALF_P) >>> 16);
        idx_d       = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          ret_d   = RET_RES;
          state_d = S_NMAG;
        end else begin
          state_d = S_BMUL1;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || kout_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    ptr_q  <= ptr_d;
    vptr_q <= vptr_d;
    t_q    <= t_d;
    prev_q <= prev_d;
    next_q <= next_d;
    vec_q  <= vec_d;
    flag_q <= flag_d;
    f_q    <= f_d;
    a_q    <= a_d;
    b_q    <= b_d;
    nv_q   <= nv_d;
    mag_q  <= mag_d;
    acc_q  <= acc_d;
    r_q    <= r_d;
    idx_q  <= idx_d;
    ret_q  <= ret_d;
    dneg_q <= dneg_d;
    p1_q   <= p1_d;
    if (out_load) begin
      ox_q    <= nv_q[0][31:0];
      oy_q    <= nv_q[1][31:0];
      oz_q    <= nv_q[2][31:0];
      ow_q    <= vec_q ? 32'sd0 : nv_q[3][31:0];
      oflag_q <= flag_q;
    end
  end

  assign kout_o.valid        = out_valid_q;
  assign kout_o.out_x        = ox_q;
  assign kout_o.out_y        = oy_q;
  assign kout_o.out_z        = oz_q;
  assign kout_o.out_w        = ow_q;
  assign kout_o.out_of_range = oflag_q;

endmodule
